// File: hw/rtl/hill_cipher_block_transform_assert.svh
// Assertion macros used by the Hill cipher block transform top level.
`ifndef HILL_CIPHER_BLOCK_TRANSFORM_ASSERT_SVH
`define HILL_CIPHER_BLOCK_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define HCBT_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> (conseq)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define HCBT_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (conseq)) else $error(msg);

`endif

// File: hw/rtl/hcbt_pkg.sv
// Types, constants and helpers shared by the Hill cipher block transform.
`default_nettype none

package hcbt_pkg;

  localparam int unsigned SYMBOL_BITS   = 8;
  localparam int unsigned LANES         = 3;
  localparam int unsigned MAX_BLOCK_DEF = 3;
  localparam int unsigned MOD_BITS      = 8;
  localparam int unsigned BSIZE_BITS    = 2;
  localparam int unsigned ROW_BITS      = LANES * SYMBOL_BITS;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned PROD_BITS     = 2 * SYMBOL_BITS;
  localparam int unsigned SUM_BITS      = PROD_BITS + $clog2(LANES);
  localparam int unsigned RED_STEPS     = 3;
  localparam int unsigned RED_STAGES    = (SUM_BITS + RED_STEPS - 1) / RED_STEPS;

  localparam logic [MOD_BITS-1:0]   MODULUS_RST    = MOD_BITS'(26);
  localparam logic [BSIZE_BITS-1:0] BLOCK_SIZE_RST = BSIZE_BITS'(3);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODULUS,
    REG_BLOCK_SIZE,
    REG_KEY_ROW0,
    REG_KEY_ROW1,
    REG_KEY_ROW2
  } cfg_reg_e;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym0;
    logic [SYMBOL_BITS-1:0] sym1;
    logic [SYMBOL_BITS-1:0] sym2;
  } blk_in_t;

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] out0;
    logic [SYMBOL_BITS-1:0] out1;
    logic [SYMBOL_BITS-1:0] out2;
  } blk_out_t;

  typedef struct packed {
    logic [MOD_BITS-1:0]             modulus;
    logic [BSIZE_BITS-1:0]           block_size;
    logic [LANES-1:0][ROW_BITS-1:0]  key_row;
  } cfg_t;

  typedef logic [LANES-1:0][SUM_BITS-1:0] lane_sum_t;

  // Number of lanes in use: the block size, clipped to the lanes built.
  function automatic logic [BSIZE_BITS-1:0] clip_block(
    input logic [BSIZE_BITS-1:0] bs,
    input int unsigned           max_block
  );
    logic [BSIZE_BITS-1:0] lim;
    lim = BSIZE_BITS'(max_block);
    return (bs > lim) ? lim : bs;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hill_cipher_block_transform.sv
// Top level of the Hill cipher block transform: a pipelined row vector by key matrix product.
`default_nettype none

// The block takes one block of up to three symbols on every clock cycle in which
// start is high; busy stays low, so a transfer happens whenever start is raised.
// Each block leaves as one result on blk_o, marked by done_o for exactly one
// cycle, after its transfer has passed the product and lane sum registers,
// the reduction stages that take the remainder by the modulus (three
// conditional subtract steps per stage over the 18-bit sums) and the
// output register. Results come out in transfer order and must be taken in
// the cycle they appear, since the receiver cannot stall the pipeline. Output
// lanes at or past the block size, and all lanes when the modulus is zero, read
// zero. Configuration writes are taken on every cycle (cfg_ready_o is high); they
// must only be issued while no block is in flight, since the pipeline reads the
// live registers. Writes to indexes past the key rows are ignored.
module hill_cipher_block_transform #(
  parameter int unsigned MAX_BLOCK = hcbt_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire hcbt_pkg::blk_in_t                  blk_i,
  output logic                                    done_o,
  output hcbt_pkg::blk_out_t                      blk_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [hcbt_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [hcbt_pkg::ROW_BITS-1:0]      cfg_data_i
);
  import hcbt_pkg::*;

  // Transfer to result, in clock edges.
  localparam int unsigned PipeLatency = RED_STAGES + 3;

  cfg_t                              cfg;
  logic                              accept;
  logic [RED_STAGES:0]               red_valid;
  lane_sum_t                         red_rem [RED_STAGES+1];
  logic [BSIZE_BITS-1:0]             n_eff;
  logic [LANES-1:0][SYMBOL_BITS-1:0] out_lane;
  blk_out_t                          blk_d, blk_q;
  logic                              done_q;

  // The pipeline never stalls, so both channels are always open.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  hcbt_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Products and lane sums, each held in its own register before leaving.
  hcbt_mac #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .blk_i   (blk_i),
    .cfg_i   (cfg),
    .valid_o (red_valid[0]),
    .sum_o   (red_rem[0])
  );

  // The reduction chain walks the shift amount from the top bit of the sum down
  // to zero, RED_STEPS steps in each stage, with the valid bit traveling alongside.
  for (genvar s = 0; s < int'(RED_STAGES); s++) begin : g_red
    hcbt_mod_stage #(
      .HI_SHIFT (int'(SUM_BITS) - 1 - s * int'(RED_STEPS)),
      .STEPS    (RED_STEPS)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (red_valid[s]),
      .rem_i     (red_rem[s]),
      .modulus_i (cfg.modulus),
      .valid_o   (red_valid[s+1]),
      .rem_o     (red_rem[s+1])
    );
  end

  // Lanes outside the block, or every lane for a zero modulus, give zero. A
  // finished remainder is below the modulus and so fits one symbol.
  assign n_eff = clip_block(cfg.block_size, MAX_BLOCK);

  always_comb begin
    out_lane = '0;
    for (int i = 0; i < int'(LANES); i++) begin
      if (i < int'(n_eff) && cfg.modulus != '0) begin
        out_lane[i] = red_rem[RED_STAGES][i][SYMBOL_BITS-1:0];
      end
    end
    blk_d.out0 = out_lane[0];
    blk_d.out1 = out_lane[1];
    blk_d.out2 = out_lane[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= red_valid[RED_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign done_o = done_q;
  assign blk_o  = blk_q;

`include "hill_cipher_block_transform_assert.svh"

  // Every result traces back to a transfer a fixed number of edges earlier.
  `HCBT_ASSERT_IMP(a_done_latency, done_o, ($past(accept, PipeLatency)), "result without a matching transfer")

  // The output register sits directly behind the last reduction stage.
  `HCBT_ASSERT_NXT(a_done_follows_chain, red_valid[RED_STAGES], done_o, "finished remainder lost at the output register")

  // A result never holds a symbol at or above a nonzero modulus.
  `HCBT_ASSERT_IMP(a_out_below_mod, (done_o && cfg.modulus != '0), (blk_o.out0 < cfg.modulus && blk_o.out1 < cfg.modulus && blk_o.out2 < cfg.modulus), "result symbol not reduced")

  // Lanes one and two read zero whenever fewer than two lanes are in use.
  `HCBT_ASSERT_IMP(a_unused_lanes_zero, (done_o && n_eff < BSIZE_BITS'(2)), (blk_o.out1 == '0 && blk_o.out2 == '0), "lane past the block size not zero")

endmodule

`default_nettype wire

// File: hw/rtl/hcbt_cfg_regs.sv
// Configuration register file of the Hill cipher block transform.
`default_nettype none

module hcbt_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wr_en_i,
  input  wire logic [hcbt_pkg::CFG_IDX_BITS-1:0]  wr_index_i,
  input  wire logic [hcbt_pkg::ROW_BITS-1:0]      wr_data_i,
  output hcbt_pkg::cfg_t                          cfg_o
);
  import hcbt_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus    <= MODULUS_RST;
      cfg_q.block_size <= BLOCK_SIZE_RST;
      // The key resets to the identity matrix.
      for (int r = 0; r < int'(LANES); r++) begin
        cfg_q.key_row[r] <= ROW_BITS'(1) << (r * int'(SYMBOL_BITS));
      end
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        REG_MODULUS:    cfg_q.modulus    <= wr_data_i[MOD_BITS-1:0];
        REG_BLOCK_SIZE: cfg_q.block_size <= wr_data_i[BSIZE_BITS-1:0];
        REG_KEY_ROW0:   cfg_q.key_row[0] <= wr_data_i;
        REG_KEY_ROW1:   cfg_q.key_row[1] <= wr_data_i;
        REG_KEY_ROW2:   cfg_q.key_row[2] <= wr_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/hcbt_mac.sv
// Multiply stage and lane sum stage of the Hill cipher block transform.
`default_nettype none

module hcbt_mac #(
  parameter int unsigned MAX_BLOCK = hcbt_pkg::MAX_BLOCK_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire hcbt_pkg::blk_in_t  blk_i,
  input  wire hcbt_pkg::cfg_t     cfg_i,
  output logic                    valid_o,
  output hcbt_pkg::lane_sum_t     sum_o
);
  import hcbt_pkg::*;

  logic [BSIZE_BITS-1:0]                     n_eff;
  logic [LANES-1:0][SYMBOL_BITS-1:0]         sym;
  logic [LANES-1:0][LANES-1:0][PROD_BITS-1:0] prod_d, prod_q;
  logic                                      prod_vld_q;
  lane_sum_t                                 sum_d, sum_q;
  logic                                      sum_vld_q;

  assign n_eff  = clip_block(cfg_i.block_size, MAX_BLOCK);
  assign sym[0] = blk_i.sym0;
  assign sym[1] = blk_i.sym1;
  assign sym[2] = blk_i.sym2;

  // Product of symbol j and key entry (j, i); symbols past the block are dropped.
  always_comb begin
    prod_d = '0;
    for (int j = 0; j < int'(MAX_BLOCK); j++) begin
      for (int i = 0; i < int'(MAX_BLOCK); i++) begin
        if (j < int'(n_eff)) begin
          prod_d[j][i] = PROD_BITS'(sym[j]) *
                         PROD_BITS'(cfg_i.key_row[j][i*SYMBOL_BITS +: SYMBOL_BITS]);
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < int'(LANES); i++) begin
      for (int j = 0; j < int'(LANES); j++) begin
        sum_d[i] = sum_d[i] + SUM_BITS'(prod_q[j][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
    end else begin
      prod_vld_q <= valid_i;
      sum_vld_q  <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign valid_o = sum_vld_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

// File: hw/rtl/hcbt_mod_stage.sv
// One stage of the pipelined modulo reduction of the lane sums.
`default_nettype none

module hcbt_mod_stage #(
  parameter int          HI_SHIFT = 17,
  parameter int unsigned STEPS    = hcbt_pkg::RED_STEPS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire hcbt_pkg::lane_sum_t            rem_i,
  input  wire logic [hcbt_pkg::MOD_BITS-1:0]  modulus_i,
  output logic                                valid_o,
  output hcbt_pkg::lane_sum_t                 rem_o
);
  import hcbt_pkg::*;

  localparam int unsigned DvsW = SUM_BITS + MOD_BITS;

  lane_sum_t rem_d, rem_q;
  logic      vld_q;

  // Each step subtracts the modulus shifted left by k when it fits, so the
  // remainder ends below the modulus shifted by k.
  always_comb begin : p_reduce
    logic [DvsW-1:0] acc;
    logic [DvsW-1:0] dvs;
    rem_d = '0;
    acc   = '0;
    dvs   = '0;
    for (int l = 0; l < int'(LANES); l++) begin
      acc = DvsW'(rem_i[l]);
      for (int t = 0; t < int'(STEPS); t++) begin
        if (HI_SHIFT - t >= 0) begin
          dvs = DvsW'(modulus_i) << (HI_SHIFT - t);
          if (acc >= dvs) begin
            acc = acc - dvs;
          end
        end
      end
      rem_d[l] = acc[SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

  assign valid_o = vld_q;
  assign rem_o   = rem_q;

endmodule

`default_nettype wire
